// ===== sv/smae_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smae_pkg
// Shared types and constants for the STUN mapped address extractor.
// ----------------------------------------------------------------------------
package smae_pkg;

  localparam logic [31:0] MagicCookie = 32'h2112_A442;
  localparam logic [15:0] XmaType     = 16'h0020;
  localparam logic [7:0]  FamilyIpv4  = 8'h01;
  localparam logic [4:0]  HeaderBytes = 5'd20;

  // parse phase, one-hot
  typedef enum logic [4:0] {
    PhHeader   = 5'b00001,
    PhAttrHead = 5'b00010,
    PhSkip     = 5'b00100,
    PhXma      = 5'b01000,
    PhDone     = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    StFound       = 2'd0,
    StUnsupported = 2'd1,
    StNotFound    = 2'd2
  } status_e;

  typedef struct packed {
    phase_e      phase;
    logic [4:0]  header_count;
    logic [16:0] attr_offset;
    logic [15:0] attr_type;
    logic [15:0] attr_length;
    logic [15:0] port_accum;
    logic [31:0] address_accum;
    logic        result_given;
  } state_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] ipv4_addr;
    logic [15:0] port;
  } result_t;

  localparam state_t StateReset = '{
    phase:         PhHeader,
    header_count:  5'd0,
    attr_offset:   17'd0,
    attr_type:     16'd0,
    attr_length:   16'd0,
    port_accum:    16'd0,
    address_accum: 32'd0,
    result_given:  1'b0
  };

endpackage

// ===== sv/smae_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smae_in_if
// Byte stream channel into the extractor: one message byte and a last mark.
// ----------------------------------------------------------------------------
interface smae_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== sv/smae_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smae_out_if
// Result channel of the extractor: status, decoded address and port.
// ----------------------------------------------------------------------------
interface smae_out_if;
  logic                 valid;
  logic                 ready;
  smae_pkg::status_e    status;
  logic [31:0]          ipv4_addr;
  logic [15:0]          port;

  modport source (output valid, output status, output ipv4_addr, output port,
                  input ready);
  modport sink   (input valid, input status, input ipv4_addr, input port,
                  output ready);
endinterface

// ===== sv/stun_mapped_address_extractor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stun_mapped_address_extractor_unit
// Pulls the XOR-MAPPED-ADDRESS (IPv4) out of a byte stream of STUN messages.
// ----------------------------------------------------------------------------
// Feed one message byte per transaction in wire order, marking the final byte
// with last_byte. The unit skips the 20-byte header, walks the attributes
// (values padded to four bytes) and on the first attribute of type 0x0020
// gives one result: status 0 with the decoded address and port for IPv4,
// status 1 at the family byte for any other family. If the message ends with
// nothing found, the final byte gives status 2. At most one result per
// message; address and port are zero unless status is 0. The unit takes one
// byte every clock cycle: an input register feeds a single per-byte parser
// step that writes the result register, so each byte passes through the input
// register and its result then through the result register. Back-pressure on
// the result channel stalls the input once both registers are full.
// ----------------------------------------------------------------------------
module stun_mapped_address_extractor_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  smae_in_if.sink    in_i,
  smae_out_if.source out_o
);

  // input register
  logic              in_vld_q;
  logic [7:0]        in_byte_q;
  logic              in_last_q;

  // parser state and result register
  smae_pkg::state_t  state_q;
  smae_pkg::state_t  state_d;
  logic              out_vld_q;
  smae_pkg::result_t out_res_q;

  logic              step_res_vld;
  smae_pkg::result_t step_res;
  logic              advance;

  // the held byte is processed once the result register can take a result
  assign advance  = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  smae_step u_step (
    .state_i     (state_q),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .state_o     (state_d),
    .res_valid_o (step_res_vld),
    .res_o       (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  // parser state moves on one byte per processed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smae_pkg::StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= step_res_vld;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step_res_vld) begin
      out_res_q <= step_res;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.status    = out_res_q.status;
  assign out_o.ipv4_addr = out_res_q.ipv4_addr;
  assign out_o.port      = out_res_q.port;

endmodule

// ===== sv/smae_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smae_step
// Per-byte parser step: next parse state and the result the byte gives.
// ----------------------------------------------------------------------------
module smae_step (
  input  smae_pkg::state_t  state_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output smae_pkg::state_t  state_o,
  output logic              res_valid_o,
  output smae_pkg::result_t res_o
);

  logic [4:0]  hdr_inc;
  logic [16:0] off_inc;
  logic [15:0] len_new;
  logic [16:0] pad_new;
  logic [16:0] pad_cur;
  logic [31:0] addr_new;

  assign hdr_inc  = state_i.header_count + 5'd1;
  assign off_inc  = state_i.attr_offset + 17'd1;
  assign len_new  = {state_i.attr_length[7:0], data_byte_i};
  // values padded up to a multiple of four bytes
  assign pad_new  = ({1'b0, len_new} + 17'd3) & 17'h1FFFC;
  assign pad_cur  = ({1'b0, state_i.attr_length} + 17'd3) & 17'h1FFFC;
  assign addr_new = {state_i.address_accum[23:0], data_byte_i};

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '{status: smae_pkg::StFound, ipv4_addr: 32'd0, port: 16'd0};

    case (state_i.phase)
      smae_pkg::PhHeader: begin
        state_o.header_count = hdr_inc;
        if (hdr_inc >= smae_pkg::HeaderBytes) begin
          state_o.phase       = smae_pkg::PhAttrHead;
          state_o.attr_offset = 17'd0;
        end
      end
      smae_pkg::PhAttrHead: begin
        if (state_i.attr_offset < 17'd2) begin
          state_o.attr_type = {state_i.attr_type[7:0], data_byte_i};
        end else begin
          state_o.attr_length = len_new;
        end
        if (state_i.attr_offset >= 17'd3) begin
          state_o.attr_offset = 17'd0;
          if (state_i.attr_type == smae_pkg::XmaType) begin
            state_o.phase = smae_pkg::PhXma;
          end else if (pad_new == 17'd0) begin
            state_o.phase = smae_pkg::PhAttrHead;
          end else begin
            state_o.phase = smae_pkg::PhSkip;
          end
        end else begin
          state_o.attr_offset = off_inc;
        end
      end
      smae_pkg::PhSkip: begin
        if (off_inc >= pad_cur) begin
          state_o.phase       = smae_pkg::PhAttrHead;
          state_o.attr_offset = 17'd0;
        end else begin
          state_o.attr_offset = off_inc;
        end
      end
      smae_pkg::PhXma: begin
        state_o.attr_offset = off_inc;
        if (state_i.attr_offset == 17'd1) begin
          // family byte, the reserved byte before it is dropped
          if (data_byte_i != smae_pkg::FamilyIpv4) begin
            res_valid_o          = 1'b1;
            res_o.status         = smae_pkg::StUnsupported;
            state_o.result_given = 1'b1;
            state_o.phase        = smae_pkg::PhDone;
          end
        end else if (state_i.attr_offset inside {17'd2, 17'd3}) begin
          state_o.port_accum = {state_i.port_accum[7:0], data_byte_i};
        end else if (state_i.attr_offset >= 17'd4) begin
          state_o.address_accum = addr_new;
          if (state_i.attr_offset >= 17'd7) begin
            res_valid_o          = 1'b1;
            res_o.status         = smae_pkg::StFound;
            res_o.ipv4_addr      = addr_new ^ smae_pkg::MagicCookie;
            res_o.port           = state_i.port_accum ^ smae_pkg::MagicCookie[31:16];
            state_o.result_given = 1'b1;
            state_o.phase        = smae_pkg::PhDone;
          end
        end
      end
      default: ;
    endcase

    if (last_byte_i) begin
      if (!res_valid_o && !state_i.result_given) begin
        res_valid_o = 1'b1;
        res_o       = '{status: smae_pkg::StNotFound, ipv4_addr: 32'd0, port: 16'd0};
      end
      state_o = smae_pkg::StateReset;
    end
  end

endmodule
